// ----- rtl/sfcx_pkg.sv -----
package sfcx_pkg;

    // Frame layout codes
    localparam logic [7:0] STX_CODE = 8'h02;
    localparam logic [7:0] CR_CODE  = 8'h0D;
    localparam logic [7:0] LF_CODE  = 8'h0A;

    // STX, ETX position, checksum, CR, LF
    localparam int MIN_FRAME = 5;

    // Default buffer depth in bytes
    localparam int MAX_FRAME_DEF = 64;

    // Result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_FMT  = 2'd1;
    localparam logic [1:0] STAT_BAD_CHK  = 2'd2;
    localparam logic [1:0] STAT_TOO_LONG = 2'd3;

    // Input word: one received byte
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_word_t;

    // Output word: one result
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic [1:0] status;
        logic       end_of_result;
    } out_word_t;

endpackage

// ----- rtl/stx_frame_checker_xor_core.sv -----
// STX frame checker with XOR checksum.
//
// Input channel (s_valid/s_ready/s_data): one received byte per word, with
// frame_end set on the last byte of a response frame. Bytes go into a
// MAX_FRAME deep buffer memory; the format and checksum tests are tracked on
// the fly, so the verdict is ready on the cycle the last byte is taken.
// Result channel (m_valid/m_ready/m_data): for a good frame the payload bytes
// come out one per word with end_of_result on the last; an empty payload, a
// bad frame or an overlong frame gives a single word with byte_present low.
//
// Throughput: one input byte per cycle while a frame is received. After the
// last byte the payload is read back from the buffer, one read and one output
// load per byte; a read waits for a free output register, and the next read
// waits until the single read port has returned the data. A status word
// leaves once the output register is free. Input is held off while results
// are being produced; a word waiting in the output register does not block
// new bytes. A stalled receiver simply holds the current result word.
// Reset (aresetn low, synchronous) clears the byte counter and handshake state; the
// buffer contents are not cleared and need no clearing pass.
module stx_frame_checker_xor_core #(
    parameter int MAX_FRAME = sfcx_pkg::MAX_FRAME_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sfcx_pkg::in_word_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sfcx_pkg::out_word_t m_data
);

    localparam int AW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam int CW = $clog2(MAX_FRAME + 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EMIT  = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                too_long_reg, too_long_next;
    logic                stx_ok_reg, stx_ok_next;
    logic [7:0]          xacc_reg, xacc_next;
    logic [7:0]          l1_reg, l1_next;
    logic [7:0]          l2_reg, l2_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic [AW-1:0]       end_addr_reg, end_addr_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                rd_last_reg, rd_last_next;
    logic [1:0]          fin_stat_reg, fin_stat_next;
    logic                m_valid_reg, m_valid_next;
    sfcx_pkg::out_word_t m_data_reg, m_data_next;

    logic [7:0] frame_mem [MAX_FRAME];
    logic [7:0] rd_data_reg;
    logic       mem_we;
    logic       rd_en;

    logic          s_accept;
    logic          m_free;
    logic          room;
    logic [CW-1:0] n_bytes;
    logic [CW-1:0] plen;
    logic          fmt_ok;
    logic          chk_ok;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign m_free   = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Frame-end tests, based on the bytes seen so far plus the current one
    assign room    = (count_reg < CW'(MAX_FRAME));
    assign n_bytes = room ? (count_reg + CW'(1)) : count_reg;
    assign plen    = n_bytes - CW'(sfcx_pkg::MIN_FRAME);
    assign fmt_ok  = (n_bytes >= CW'(sfcx_pkg::MIN_FRAME)) && stx_ok_reg &&
                     (l1_reg == sfcx_pkg::CR_CODE) &&
                     (s_data.rx_byte == sfcx_pkg::LF_CODE);
    // xacc covers bytes 1..n-2; strip CR and checksum to get 1..n-4
    assign chk_ok  = ((xacc_reg ^ l1_reg ^ l2_reg) == l2_reg);

    // Next-state logic
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg;
        stx_ok_next   = stx_ok_reg;
        xacc_next     = xacc_reg;
        l1_next       = l1_reg;
        l2_next       = l2_reg;
        rd_addr_next  = rd_addr_reg;
        end_addr_next = end_addr_reg;
        rd_pend_next  = rd_pend_reg;
        rd_last_next  = rd_last_reg;
        fin_stat_next = fin_stat_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        rd_en         = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    l1_next = s_data.rx_byte;
                    l2_next = l1_reg;
                    if (room) begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0) begin
                            stx_ok_next = (s_data.rx_byte == sfcx_pkg::STX_CODE);
                        end else begin
                            xacc_next = xacc_reg ^ s_data.rx_byte;
                        end
                    end else begin
                        too_long_next = 1'b1;
                    end

                    if (s_data.frame_end) begin
                        count_next    = '0;
                        too_long_next = 1'b0;
                        xacc_next     = '0;
                        state_next    = ST_FINAL;
                        if (too_long_reg || !room) begin
                            fin_stat_next = sfcx_pkg::STAT_TOO_LONG;
                        end else if (!fmt_ok) begin
                            fin_stat_next = sfcx_pkg::STAT_BAD_FMT;
                        end else if (!chk_ok) begin
                            fin_stat_next = sfcx_pkg::STAT_BAD_CHK;
                        end else if (plen == '0) begin
                            fin_stat_next = sfcx_pkg::STAT_OK;
                        end else begin
                            state_next    = ST_EMIT;
                            rd_addr_next  = AW'(1);
                            end_addr_next = plen[AW-1:0];
                            rd_pend_next  = 1'b0;
                        end
                    end
                end
            end

            ST_EMIT: begin
                // Land the pending read in the output register
                if (rd_pend_reg) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{data_byte:     rd_data_reg,
                                     byte_present:  1'b1,
                                     status:        sfcx_pkg::STAT_OK,
                                     end_of_result: rd_last_reg};
                    rd_pend_next = 1'b0;
                    if (rd_last_reg) begin
                        state_next = ST_IDLE;
                    end
                end else if (m_free) begin
                    // Issue the next payload read
                    rd_en        = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_last_next = (rd_addr_reg == end_addr_reg);
                    rd_addr_next = rd_addr_reg + AW'(1);
                end
            end

            ST_FINAL: begin
                if (m_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{data_byte:     8'h00,
                                     byte_present:  1'b0,
                                     status:        fin_stat_reg,
                                     end_of_result: 1'b1};
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            too_long_reg <= 1'b0;
            xacc_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            too_long_reg <= too_long_next;
            xacc_reg     <= xacc_next;
            rd_pend_reg  <= rd_pend_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        stx_ok_reg   <= stx_ok_next;
        l1_reg       <= l1_next;
        l2_reg       <= l2_next;
        rd_addr_reg  <= rd_addr_next;
        end_addr_reg <= end_addr_next;
        rd_last_reg  <= rd_last_next;
        fin_stat_reg <= fin_stat_next;
        m_data_reg   <= m_data_next;
    end

    // Frame buffer: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            frame_mem[count_reg[AW-1:0]] <= s_data.rx_byte;
        end
        if (rd_en) begin
            rd_data_reg <= frame_mem[rd_addr_reg];
        end
    end

    // A pending read always finds the output register free
    a_pend_free: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (!m_valid_reg || m_ready))
        else $error("read data landed while output word was held");

    // Reads are only in flight while emitting
    a_pend_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_EMIT))
        else $error("read pending outside emit state");

    // Byte count never passes the buffer depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_FRAME))
        else $error("byte count beyond buffer depth");

    // A word without a payload byte always closes the frame
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.byte_present) |-> m_data.end_of_result)
        else $error("status word without end marker");

    // Frame end stops input until results are out
    a_end_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_data.frame_end) |=> !s_ready)
        else $error("input taken right after frame end");

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_FRAME    = sfcx_pkg::MAX_FRAME_DEF;
    localparam logic [7:0] ETX_CODE = 8'h03;
    localparam int DIR_ROWS     = 23;
    localparam int ITEM_TARGET  = 175;
    localparam int PHASE1_AT    = 60;
    localparam int PHASE2_AT    = 120;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT  = 5000;

    // Words that can be read straight off the frame layout
    localparam sfcx_pkg::out_word_t NO_WANT    = '0;
    localparam sfcx_pkg::out_word_t WANT_FMT   = {8'h00, 1'b0, sfcx_pkg::STAT_BAD_FMT, 1'b1};
    localparam sfcx_pkg::out_word_t WANT_CHK   = {8'h00, 1'b0, sfcx_pkg::STAT_BAD_CHK, 1'b1};
    localparam sfcx_pkg::out_word_t WANT_EMPTY = {8'h00, 1'b0, sfcx_pkg::STAT_OK, 1'b1};

    typedef struct packed {
        logic [7:0]          rx;
        logic                last;
        logic                typed;
        sfcx_pkg::out_word_t want;
    } dir_row_t;

    typedef enum int {
        FRM_GOOD, FRM_FULL, FRM_OVERSIZE, FRM_BAD_STX, FRM_BAD_CR,
        FRM_BAD_LF, FRM_BAD_SUM, FRM_SHORT, FRM_NOISE
    } frame_kind_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sfcx_pkg::in_word_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sfcx_pkg::out_word_t m_data;

    stx_frame_checker_xor_core #(.MAX_FRAME(MAX_FRAME)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Shadow copy of the frame buffer and its counters
    logic [7:0]  frame_buf [MAX_FRAME];
    int unsigned buf_fill = 0;
    bit          buf_overrun = 1'b0;

    sfcx_pkg::out_word_t expected_words[$];
    int          mismatches = 0;
    int          items_sent = 0;
    int          idle_phase = 0;
    int          stall_cycles = 0;
    dir_row_t    dir_rows [DIR_ROWS];

    // Store one byte; at frame end queue the words the frame should give
    function automatic int take_frame_byte(input sfcx_pkg::in_word_t w);
        int unsigned         n;
        int unsigned         i;
        logic [7:0]          sum;
        logic [1:0]          verdict;
        sfcx_pkg::out_word_t o;
        if (buf_fill < MAX_FRAME) begin
            frame_buf[buf_fill] = w.rx_byte;
            buf_fill++;
        end else begin
            buf_overrun = 1'b1;
        end
        if (!w.frame_end) return 0;

        n = buf_fill;
        verdict = sfcx_pkg::STAT_OK;
        if (buf_overrun) begin
            verdict = sfcx_pkg::STAT_TOO_LONG;
        end else if (n < sfcx_pkg::MIN_FRAME || frame_buf[0] != sfcx_pkg::STX_CODE ||
                     frame_buf[n-2] != sfcx_pkg::CR_CODE ||
                     frame_buf[n-1] != sfcx_pkg::LF_CODE) begin
            verdict = sfcx_pkg::STAT_BAD_FMT;
        end else begin
            // XOR over payload and ETX position, STX excluded
            sum = 8'h00;
            for (i = 1; i + 4 <= n; i++) sum ^= frame_buf[i];
            if (sum != frame_buf[n-3]) verdict = sfcx_pkg::STAT_BAD_CHK;
        end
        buf_fill = 0;
        buf_overrun = 1'b0;

        if (verdict != sfcx_pkg::STAT_OK || n == sfcx_pkg::MIN_FRAME) begin
            o = '0;
            o.status = verdict;
            o.end_of_result = 1'b1;
            expected_words.push_back(o);
            return 1;
        end
        for (i = 1; i <= n - 5; i++) begin
            o.data_byte     = frame_buf[i];
            o.byte_present  = 1'b1;
            o.status        = sfcx_pkg::STAT_OK;
            o.end_of_result = (i == n - 5);
            expected_words.push_back(o);
        end
        return n - 5;
    endfunction

    // Idle chance in percent for the current phase
    function automatic int idle_pct(input bit is_sender);
        case (idle_phase)
            0: return is_sender ? 31 : 78;
            1: return is_sender ? 78 : 31;
            default: return 0;
        endcase
    endfunction

    // Drive one word, wait for it to be taken, then predict
    task automatic send_word(input sfcx_pkg::in_word_t w, output int produced);
        int gap;
        gap = 0;
        idle_phase = (items_sent < PHASE1_AT) ? 0 : (items_sent < PHASE2_AT) ? 1 : 2;
        while ($urandom_range(99) < idle_pct(1'b1)) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        produced = take_frame_byte(w);
    endtask

    // Build one frame of the given kind and send it
    task automatic send_frame(input frame_kind_t kind);
        logic [7:0]         fb[$];
        logic [7:0]         b;
        logic [7:0]         sum;
        int                 plen;
        int                 n;
        int                 i;
        int                 produced;
        sfcx_pkg::in_word_t w;
        fb.delete();
        if (kind == FRM_SHORT || kind == FRM_NOISE) begin
            n = (kind == FRM_SHORT) ? $urandom_range(1, 4) : $urandom_range(1, 12);
            repeat (n) fb.push_back(8'($urandom_range(255)));
            if (kind == FRM_SHORT && $urandom_range(1)) fb[0] = sfcx_pkg::STX_CODE;
            if (kind == FRM_SHORT && n >= 2 && $urandom_range(1)) begin
                fb[n-2] = sfcx_pkg::CR_CODE;
                fb[n-1] = sfcx_pkg::LF_CODE;
            end
        end else begin
            case (kind)
                FRM_FULL:     plen = MAX_FRAME - sfcx_pkg::MIN_FRAME;
                FRM_OVERSIZE: plen = $urandom_range(MAX_FRAME - sfcx_pkg::MIN_FRAME + 1,
                                                    MAX_FRAME - sfcx_pkg::MIN_FRAME + 3);
                default:      plen = $urandom_range(0, 10);
            endcase
            fb.push_back(sfcx_pkg::STX_CODE);
            sum = 8'h00;
            repeat (plen) begin
                b = 8'($urandom_range(255));
                fb.push_back(b);
                sum ^= b;
            end
            // ETX slot is covered by the XOR but never compared
            b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : ETX_CODE;
            fb.push_back(b);
            sum ^= b;
            fb.push_back(sum);
            fb.push_back(sfcx_pkg::CR_CODE);
            fb.push_back(sfcx_pkg::LF_CODE);
            n = fb.size();
            case (kind)
                FRM_BAD_STX: fb[0]   = sfcx_pkg::STX_CODE ^ 8'($urandom_range(1, 255));
                FRM_BAD_CR:  fb[n-2] = sfcx_pkg::CR_CODE ^ 8'($urandom_range(1, 255));
                FRM_BAD_LF:  fb[n-1] = sfcx_pkg::LF_CODE ^ 8'($urandom_range(1, 255));
                FRM_BAD_SUM: fb[n-3] = fb[n-3] ^ 8'($urandom_range(1, 255));
                default: ;
            endcase
        end
        for (i = 0; i < fb.size(); i++) begin
            w.rx_byte   = fb[i];
            w.frame_end = (i == fb.size() - 1);
            send_word(w, produced);
        end
    endtask

    // Let every queued word come out with the sender held off
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // Receiver back-pressure
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end

    // Result checker
    always @(posedge aclk) begin : result_check
        sfcx_pkg::out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, m_data);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                if (m_data.data_byte !== want.data_byte) begin
                    $display("%0t: data_byte expected %h got %h",
                             $time, want.data_byte, m_data.data_byte);
                    mismatches++;
                end
                if (m_data.byte_present !== want.byte_present) begin
                    $display("%0t: byte_present expected %b got %b",
                             $time, want.byte_present, m_data.byte_present);
                    mismatches++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, m_data.status);
                    mismatches++;
                end
                if (m_data.end_of_result !== want.end_of_result) begin
                    $display("%0t: end_of_result expected %b got %b",
                             $time, want.end_of_result, m_data.end_of_result);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: cycles with no word taken on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge aclk);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin : main_seq
        int                  i;
        int                  produced;
        int                  frame_idx;
        int                  pick;
        sfcx_pkg::in_word_t  w;
        dir_row_t            row;
        sfcx_pkg::out_word_t dropped;
        frame_kind_t         kind;

        dir_rows = '{
            // lone STX with frame end: too short
            {sfcx_pkg::STX_CODE, 1'b1, 1'b1, WANT_FMT},
            // empty payload, checksum equals the ETX slot
            {sfcx_pkg::STX_CODE, 1'b0, 1'b0, NO_WANT},
            {8'hE0,              1'b0, 1'b0, NO_WANT},
            {8'hE0,              1'b0, 1'b0, NO_WANT},
            {sfcx_pkg::CR_CODE,  1'b0, 1'b0, NO_WANT},
            {sfcx_pkg::LF_CODE,  1'b1, 1'b1, WANT_EMPTY},
            // wrong checksum
            {sfcx_pkg::STX_CODE, 1'b0, 1'b0, NO_WANT},
            {ETX_CODE,           1'b0, 1'b0, NO_WANT},
            {8'h00,              1'b0, 1'b0, NO_WANT},
            {sfcx_pkg::CR_CODE,  1'b0, 1'b0, NO_WANT},
            {sfcx_pkg::LF_CODE,  1'b1, 1'b1, WANT_CHK},
            // payload with extreme byte values
            {sfcx_pkg::STX_CODE, 1'b0, 1'b0, NO_WANT},
            {8'hFF,              1'b0, 1'b0, NO_WANT},
            {8'h00,              1'b0, 1'b0, NO_WANT},
            {ETX_CODE,           1'b0, 1'b0, NO_WANT},
            {8'hFC,              1'b0, 1'b0, NO_WANT},
            {sfcx_pkg::CR_CODE,  1'b0, 1'b0, NO_WANT},
            {sfcx_pkg::LF_CODE,  1'b1, 1'b0, NO_WANT},
            // first byte not STX
            {8'hFD,              1'b0, 1'b0, NO_WANT},
            {8'h00,              1'b0, 1'b0, NO_WANT},
            {8'h00,              1'b0, 1'b0, NO_WANT},
            {sfcx_pkg::CR_CODE,  1'b0, 1'b0, NO_WANT},
            {sfcx_pkg::LF_CODE,  1'b1, 1'b1, WANT_FMT}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table
        for (i = 0; i < DIR_ROWS; i++) begin
            row = dir_rows[i];
            w.rx_byte   = row.rx;
            w.frame_end = row.last;
            send_word(w, produced);
            if (row.typed) begin
                repeat (produced) dropped = expected_words.pop_back();
                expected_words.push_back(row.want);
            end
        end
        wait_drained();

        // Random frames; one full-size and one oversize frame are forced
        frame_idx = 0;
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(99);
            if (frame_idx == 1)      kind = FRM_FULL;
            else if (frame_idx == 3) kind = FRM_OVERSIZE;
            else if (pick < 65)      kind = FRM_GOOD;
            else if (pick < 72)      kind = FRM_BAD_STX;
            else if (pick < 79)      kind = FRM_BAD_CR;
            else if (pick < 86)      kind = FRM_BAD_LF;
            else if (pick < 93)      kind = FRM_BAD_SUM;
            else if (pick < 97)      kind = FRM_SHORT;
            else                     kind = FRM_NOISE;
            send_frame(kind);
            frame_idx++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sfcx_pkg.sv
rtl/stx_frame_checker_xor_core.sv
verif/testbench.sv
